// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pfre_pkg.sv
// ----------------------------------------------------------------------------
// pfre_pkg
// Types and constants of the fractional PLL register encoder.
// ----------------------------------------------------------------------------
package pfre_pkg;

    // Field widths.
    localparam int INT_W    = 11;
    localparam int FRAC_W   = 20;
    localparam int REG_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int P1_W     = 18;

    // The numerator is scaled by 128 before the division.
    localparam int FRAC_SHIFT = 7;
    localparam int DIV_BITS   = FRAC_W + FRAC_SHIFT;

    // Eight parameter bytes per request.
    localparam int NUM_BYTES = 8;
    localparam int CNT_W     = 3;

    // Offset subtracted from P1.
    localparam logic [P1_W-1:0] P1_OFFSET = 18'd512;

    // Data travelling along the divider chain, one request per stage.
    typedef struct packed {
        logic                   valid;
        logic                   div_err;
        logic [INT_W-1:0]       mult_int;
        logic [FRAC_W-1:0]      frac_den;
        logic [REG_W-1:0]       first_reg;
        logic [FRAC_W-1:0]      rem;
        logic [DIV_BITS-1:0]    shreg;
    } stage_t;

endpackage

// File: src/pfre_div_cell.sv
// ----------------------------------------------------------------------------
// pfre_div_cell
// One restoring-division cell: develops one quotient bit per request.
// ----------------------------------------------------------------------------
module pfre_div_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  pfre_pkg::stage_t stage_in,
    output pfre_pkg::stage_t stage_out
);

    logic                             valid_reg;
    pfre_pkg::stage_t                 data_reg;
    pfre_pkg::stage_t                 data_next;
    logic [pfre_pkg::FRAC_W:0]        trial;
    logic [pfre_pkg::FRAC_W:0]        diff;
    logic                             fits;

    // Bring down the next dividend bit and try to subtract the denominator.
    // The shift register takes the dividend out at the top and the quotient
    // in at the bottom.
    always_comb
    begin
        trial = {stage_in.rem, stage_in.shreg[pfre_pkg::DIV_BITS-1]};
        diff  = trial - {1'b0, stage_in.frac_den};
        fits  = (trial >= {1'b0, stage_in.frac_den});

        data_next       = stage_in;
        data_next.rem   = fits ? diff[pfre_pkg::FRAC_W-1:0]
                               : trial[pfre_pkg::FRAC_W-1:0];
        data_next.shreg = {stage_in.shreg[pfre_pkg::DIV_BITS-2:0], fits};
    end

    // Valid flag of this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload of this stage.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// File: src/pfre_byte_out.sv
// ----------------------------------------------------------------------------
// pfre_byte_out
// Packs P1, P2 and P3 into eight bytes and emits them one per cycle, or one error byte.
// ----------------------------------------------------------------------------
module pfre_byte_out
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pfre_pkg::stage_t                stage_in,
    output logic                            strobe,
    output logic [pfre_pkg::REG_W-1:0]      reg_addr,
    output logic [pfre_pkg::BYTE_W-1:0]     data_byte,
    output logic                            last,
    output logic                            div_error
);

    localparam int TAIL_W = (pfre_pkg::NUM_BYTES - 1) * pfre_pkg::BYTE_W;

    logic                           strobe_reg;
    logic                           strobe_next;
    logic [pfre_pkg::CNT_W-1:0]     cnt_reg;
    logic [pfre_pkg::CNT_W-1:0]     cnt_next;
    logic [pfre_pkg::REG_W-1:0]     addr_reg;
    logic [pfre_pkg::REG_W-1:0]     addr_next;
    logic [pfre_pkg::BYTE_W-1:0]    byte_reg;
    logic [pfre_pkg::BYTE_W-1:0]    byte_next;
    logic                           last_reg;
    logic                           last_next;
    logic                           err_reg;
    logic                           err_next;
    logic [TAIL_W-1:0]              tail_reg;
    logic [TAIL_W-1:0]              tail_next;
    logic [pfre_pkg::P1_W-1:0]      p1;
    logic [pfre_pkg::FRAC_W-1:0]    p2;
    logic [pfre_pkg::FRAC_W-1:0]    p3;

    // Parameters from the finished division.
    always_comb
    begin
        p3 = stage_in.frac_den;
        p2 = stage_in.rem;
        p1 = {stage_in.mult_int, {pfre_pkg::FRAC_SHIFT{1'b0}}}
             + stage_in.shreg[pfre_pkg::P1_W-1:0] - pfre_pkg::P1_OFFSET;
    end

    // A finished request loads the first byte and the seven that follow;
    // otherwise the remaining bytes shift out one per cycle.
    always_comb
    begin
        strobe_next = 1'b0;
        cnt_next    = cnt_reg;
        addr_next   = addr_reg;
        byte_next   = byte_reg;
        last_next   = 1'b0;
        err_next    = 1'b0;
        tail_next   = tail_reg;

        if (stage_in.valid)
        begin
            strobe_next = 1'b1;
            if (stage_in.div_err)
            begin
                addr_next = '0;
                byte_next = '0;
                last_next = 1'b1;
                err_next  = 1'b1;
                cnt_next  = '0;
            end
            else
            begin
                addr_next = stage_in.first_reg;
                byte_next = p3[15:8];
                cnt_next  = pfre_pkg::CNT_W'(pfre_pkg::NUM_BYTES - 1);
                tail_next = {p3[7:0],
                             6'b0, p1[17:16],
                             p1[15:8],
                             p1[7:0],
                             p3[19:16], p2[19:16],
                             p2[15:8],
                             p2[7:0]};
            end
        end
        else if (cnt_reg != '0)
        begin
            strobe_next = 1'b1;
            addr_next   = addr_reg + 8'd1;
            byte_next   = tail_reg[TAIL_W-1 -: pfre_pkg::BYTE_W];
            tail_next   = {tail_reg[TAIL_W-pfre_pkg::BYTE_W-1:0], {pfre_pkg::BYTE_W{1'b0}}};
            last_next   = (cnt_reg == pfre_pkg::CNT_W'(1));
            cnt_next    = cnt_reg - pfre_pkg::CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        tail_reg <= tail_next;
    end

    assign strobe    = strobe_reg;
    assign reg_addr  = addr_reg;
    assign data_byte = byte_reg;
    assign last      = last_reg;
    assign div_error = err_reg;

endmodule

// File: src/pll_fraction_register_encoder_top.sv
// ----------------------------------------------------------------------------
// pll_fraction_register_encoder_top
// Fractional PLL multisynth encoder: P1/P2/P3 and eight register bytes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake         | Fields
//  ---------+-------------------+---------------------------------------------
//  request  | start, busy       | mult_int, frac_num, frac_den, first_reg
//  result   | strobe            | reg_addr, data_byte, last, div_error
//
// A request is taken on a rising edge with start high and busy low. busy then
// stays high so that requests enter at the pace of the byte serialiser that
// sends one byte per cycle.
// The request enters the first of 27 divider cells on its own edge, each cell
// develops one quotient bit, and the output register after the last cell puts
// the bytes on the result ports. A zero denominator gives one result with
// div_error and last set. The receiver cannot stall results.
// Reset clears the valid flags of the chain and the serialiser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pll_fraction_register_encoder_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pfre_pkg::INT_W-1:0]      mult_int,
    input  logic [pfre_pkg::FRAC_W-1:0]     frac_num,
    input  logic [pfre_pkg::FRAC_W-1:0]     frac_den,
    input  logic [pfre_pkg::REG_W-1:0]      first_reg,
    output logic                            strobe,
    output logic [pfre_pkg::REG_W-1:0]      reg_addr,
    output logic [pfre_pkg::BYTE_W-1:0]     data_byte,
    output logic                            last,
    output logic                            div_error
);

    pfre_pkg::stage_t               chain [0:pfre_pkg::DIV_BITS];
    logic [pfre_pkg::CNT_W-1:0]     gap_reg;
    logic [pfre_pkg::CNT_W-1:0]     gap_next;
    logic                           accept;

    assign accept = start && !busy;
    assign busy   = (gap_reg != '0);

    // Request spacing: hold busy for the rest of the slot that one byte burst takes.
    always_comb
    begin
        gap_next = gap_reg;
        if (accept)
        begin
            gap_next = pfre_pkg::CNT_W'(pfre_pkg::NUM_BYTES - 1);
        end
        else if (gap_reg != '0)
        begin
            gap_next = gap_reg - pfre_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= '0;
        end
        else
        begin
            gap_reg <= gap_next;
        end
    end

    // Head of the divider chain: scaled numerator, empty remainder.
    always_comb
    begin
        chain[0].valid     = accept;
        chain[0].div_err   = (frac_den == '0);
        chain[0].mult_int  = mult_int;
        chain[0].frac_den  = frac_den;
        chain[0].first_reg = first_reg;
        chain[0].rem       = '0;
        chain[0].shreg     = {frac_num, {pfre_pkg::FRAC_SHIFT{1'b0}}};
    end

    // One cell per quotient bit.
    for (genvar i = 0; i < pfre_pkg::DIV_BITS; i++)
    begin : g_cell
        pfre_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // Byte packing and serialisation.
    pfre_byte_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (chain[pfre_pkg::DIV_BITS]),
        .strobe    (strobe),
        .reg_addr  (reg_addr),
        .data_byte (data_byte),
        .last      (last),
        .div_error (div_error)
    );

    // An error result is always the only and last result of its request.
    `ASSERT_SAME(a_err_is_last, strobe && div_error, last, "error result without last")

    // The bytes of one request leave in consecutive cycles.
    `ASSERT_NEXT(a_bytes_contiguous, strobe && !last, strobe, "gap inside a byte burst")

    // Register addresses step by one within a burst.
    `ASSERT_NEXT(a_addr_step, strobe && !last, reg_addr == $past(reg_addr) + 8'd1,
                 "register address did not advance")

    // A taken request closes the slot for the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy not raised after request")

endmodule

// File: tb/tb_pll_fraction_register_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_pll_fraction_register_encoder_top
// Self-checking bench for the fractional PLL multisynth register encoder.
// Each request (a + b/c, first register) is predicted in the bench as the
// eight packed P1/P2/P3 bytes, or one error result when c is zero. Every strobe
// is compared field by field against the oldest pending byte. The run covers
// directed corner cases and then random requests under several sender idle
// patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pll_fraction_register_encoder_top;

    localparam int MAX_GAP        = 64;    // longest idle stretch before a request
    localparam int DRAIN_CYCLES   = 40;    // extra wait once no byte is pending
    localparam int QUIET_LIMIT    = 1000;  // cycles with no request taken and no strobe before giving up
    localparam int RANDOM_PER_TEST = 110;

    // One expected result byte.
    typedef struct packed {
        logic [pfre_pkg::REG_W-1:0]  addr;
        logic [pfre_pkg::BYTE_W-1:0] data;
        logic                        last_flag;
        logic                        err_flag;
    } pll_byte_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic                          busy;
    logic [pfre_pkg::INT_W-1:0]    mult_int  = '0;
    logic [pfre_pkg::FRAC_W-1:0]   frac_num  = '0;
    logic [pfre_pkg::FRAC_W-1:0]   frac_den  = '0;
    logic [pfre_pkg::REG_W-1:0]    first_reg = '0;
    logic                          strobe;
    logic [pfre_pkg::REG_W-1:0]    reg_addr;
    logic [pfre_pkg::BYTE_W-1:0]   data_byte;
    logic                          last;
    logic                          div_error;

    pll_byte_t pending_bytes[$];
    int        error_count  = 0;
    int        quiet_cycles = 0;
    int        idle_pct     = 0;

    pll_fraction_register_encoder_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mult_int  (mult_int),
        .frac_num  (frac_num),
        .frac_den  (frac_den),
        .first_reg (first_reg),
        .strobe    (strobe),
        .reg_addr  (reg_addr),
        .data_byte (data_byte),
        .last      (last),
        .div_error (div_error)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Work out the register bytes for one request and queue them.
    function automatic void encode_pll_setting(
        input logic [pfre_pkg::INT_W-1:0]  mult,
        input logic [pfre_pkg::FRAC_W-1:0] num,
        input logic [pfre_pkg::FRAC_W-1:0] den,
        input logic [pfre_pkg::REG_W-1:0]  base_reg
    );
        logic [26:0]  num_scaled;
        logic [31:0]  p1_full;
        logic [17:0]  p1_word;
        logic [19:0]  p2_word;
        logic [19:0]  p3_word;
        logic [7:0]   reg_bytes [pfre_pkg::NUM_BYTES];
        pll_byte_t    one_byte;
        int           k;

        // A zero denominator gives a single error result and no bytes.
        if (den == '0)
        begin
            one_byte.addr      = '0;
            one_byte.data      = '0;
            one_byte.last_flag = 1'b1;
            one_byte.err_flag  = 1'b1;
            pending_bytes.push_back(one_byte);
            return;
        end

        num_scaled = {num, 7'b0};
        p3_word    = den;
        p2_word    = pfre_pkg::FRAC_W'(num_scaled % den);
        // P1 wraps to 18 bits, both below zero and above the top.
        p1_full    = (mult << 7) + num_scaled / den - 32'd512;
        p1_word    = p1_full[17:0];

        reg_bytes[0] = p3_word[15:8];
        reg_bytes[1] = p3_word[7:0];
        reg_bytes[2] = {6'b0, p1_word[17:16]};
        reg_bytes[3] = p1_word[15:8];
        reg_bytes[4] = p1_word[7:0];
        reg_bytes[5] = {p3_word[19:16], p2_word[19:16]};
        reg_bytes[6] = p2_word[15:8];
        reg_bytes[7] = p2_word[7:0];

        for (k = 0; k < pfre_pkg::NUM_BYTES; k++)
        begin
            one_byte.addr      = base_reg + k[7:0];
            one_byte.data      = reg_bytes[k];
            one_byte.last_flag = (k == pfre_pkg::NUM_BYTES - 1);
            one_byte.err_flag  = 1'b0;
            pending_bytes.push_back(one_byte);
        end
    endfunction

    // Send one request, with a random idle stretch in front of it.
    task automatic issue_setting(
        input logic [pfre_pkg::INT_W-1:0]  mult,
        input logic [pfre_pkg::FRAC_W-1:0] num,
        input logic [pfre_pkg::FRAC_W-1:0] den,
        input logic [pfre_pkg::REG_W-1:0]  base_reg
    );
        int gap;

        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end

        start     <= 1'b1;
        mult_int  <= mult;
        frac_num  <= num;
        frac_den  <= den;
        first_reg <= base_reg;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        encode_pll_setting(mult, num, den, base_reg);
    endtask

    // Random request: mostly proper fractions, with zero and small
    // denominators and numerators at or above the denominator mixed in.
    task automatic issue_random_setting();
        logic [pfre_pkg::FRAC_W-1:0] den;
        logic [pfre_pkg::FRAC_W-1:0] num;
        int                          pick;

        pick = $urandom_range(99);
        if (pick < 6)
            den = '0;
        else if (pick < 22)
            den = pfre_pkg::FRAC_W'($urandom_range(255, 1));
        else
            den = pfre_pkg::FRAC_W'($urandom_range(20'hFFFFF, 1));

        if (den == '0 || pick >= 85)
            num = pfre_pkg::FRAC_W'($urandom_range(20'hFFFFF, 0));
        else if (pick < 30)
            num = pfre_pkg::FRAC_W'($urandom_range(20'hFFFFF, den));
        else
            num = pfre_pkg::FRAC_W'($urandom_range(den - 1, 0));

        issue_setting(pfre_pkg::INT_W'($urandom_range(2047, 0)), num, den,
                      pfre_pkg::REG_W'($urandom_range(255, 0)));
    endtask

    // Corners: zero denominator, P1 below zero, register wrap, field extremes.
    task automatic test_directed_corners();
        idle_pct = 0;
        issue_setting(11'd0,    20'h00000, 20'h00000, 8'h00);
        issue_setting(11'h7FF,  20'hFFFFF, 20'h00000, 8'hFF);
        issue_setting(11'd0,    20'h00000, 20'h00001, 8'h00);
        issue_setting(11'd4,    20'h00000, 20'h00001, 8'h10);
        issue_setting(11'd3,    20'h00000, 20'h00001, 8'h20);
        issue_setting(11'h7FF,  20'h00000, 20'h00001, 8'hF8);
        issue_setting(11'h7FF,  20'hFFFFF, 20'h00001, 8'hFF);
        issue_setting(11'd35,   20'h00001, 20'hFFFFF, 8'h1A);
        issue_setting(11'd35,   20'hFFFFE, 20'hFFFFF, 8'h2A);
        issue_setting(11'd100,  20'd500,   20'd500,   8'h30);
        issue_setting(11'd90,   20'd3,     20'd7,     8'hFD);
        issue_setting(11'd512,  20'hFFFFF, 20'd3,     8'h80);
        issue_setting(11'h555,  20'hAAAAA, 20'h55555, 8'hAA);
        issue_setting(11'h2AA,  20'h55555, 20'hAAAAA, 8'h55);
        issue_setting(11'h400,  20'h80000, 20'h00000, 8'h7F);
        issue_setting(11'd1,    20'hFFFFF, 20'hFFFFF, 8'hF9);
    endtask

    // Requests offered on every cycle the block will take them.
    task automatic test_back_to_back();
        idle_pct = 0;
        repeat (RANDOM_PER_TEST) issue_random_setting();
    endtask

    // Sender idle most of the time, so requests land on every phase.
    task automatic test_sparse_requests();
        idle_pct = 79;
        repeat (RANDOM_PER_TEST) issue_random_setting();
    endtask

    // Occasional short sender gaps.
    task automatic test_light_idle();
        idle_pct = 20;
        repeat (RANDOM_PER_TEST) issue_random_setting();
    endtask

    // Compare each strobed result with the oldest pending byte.
    always @(posedge clk)
    begin : compare_results
        pll_byte_t want;

        if (rst_n && strobe === 1'b1)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result addr=%02h data=%02h",
                                          reg_addr, data_byte));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (reg_addr !== want.addr)
                    report_mismatch($sformatf("reg_addr %02h, wanted %02h",
                                              reg_addr, want.addr));
                if (data_byte !== want.data)
                    report_mismatch($sformatf("data_byte %02h, wanted %02h (addr %02h)",
                                              data_byte, want.data, want.addr));
                if (last !== want.last_flag)
                    report_mismatch($sformatf("last %b, wanted %b (addr %02h)",
                                              last, want.last_flag, want.addr));
                if (div_error !== want.err_flag)
                    report_mismatch($sformatf("div_error %b, wanted %b",
                                              div_error, want.err_flag));
            end
        end
    end

    // Watchdog: end the run if no request is taken and no result strobed for too long.
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_back_to_back();
        test_sparse_requests();
        test_light_idle();

        // Let the remaining bytes drain out.
        start <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
